/* src/hrf_pkg.sv */
// Package for the HTTP response framer: phase and role codes, sizes, key text.
`default_nettype none
package hrf_pkg;

  localparam int LenW    = 32;           // width of the Content-Length counters
  localparam int CodeW   = 10;           // status code width
  localparam int KeyLen  = 14;           // length of "Content-Length"
  localparam int KeyIdxW = 4;            // index into the key text
  localparam logic [CodeW-1:0] CodeMax = CodeW'(999);
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_VERSION = 7'b0000001,
    PH_CODE    = 7'b0000010,
    PH_REASON  = 7'b0000100,
    PH_NAME    = 7'b0001000,
    PH_VALUE   = 7'b0010000,
    PH_BODY    = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  // Role tag of each byte.
  typedef enum logic [2:0] {
    ROLE_VERSION  = 3'd0,
    ROLE_CODE     = 3'd1,
    ROLE_REASON   = 3'd2,
    ROLE_NAME     = 3'd3,
    ROLE_VALUE    = 3'd4,
    ROLE_SEP      = 3'd5,
    ROLE_BODY     = 3'd6,
    ROLE_UNUSED   = 3'd7
  } role_t;

  // Character of "Content-Length" at a given position.
  function automatic logic [7:0] key_char(input logic [KeyIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/http_response_framer.sv */
// Top level of the HTTP response framer: byte-serial HTTP/1.1 response tagger.
`default_nettype none
// Takes one HTTP/1.1 response one byte per beat and returns one result beat
// per input beat: the byte, its role (version, code, reason, header name,
// header value, separator, body, not consumed) and the running parse status
// (status code saturating at 999, status line done, headers done, the last
// committed Content-Length value, message done). Only a header name equal to
// "Content-Length" (case sensitive) commits its value; the last such line
// wins. A header line with no colon, the empty line included, ends the
// headers, and the body is then counted down; with no length or a zero
// length the message completes on that line's LF. After completion each byte
// is tagged not consumed and no state changes. Throughput is one byte per
// clock with no gaps while the output is not backpressured: the input
// register feeds a combinational parse step that writes the result
// register, so each beat passes the input register, then the result
// register. That rate is set by the parse state loop. Backpressure on the
// output stalls both registers; the input side stays ready whenever the
// result register is free or drains.
module http_response_framer
  import hrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // chunk_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [7:0] echo_byte, [8] consumed,
                                       // [18:9] status_code, [19] status_line_done,
                                       // [20] headers_done, [52:21] content_length,
                                       // [53] message_done, [55:54] zero
  output logic [2:0]       out_tuser,  // [2:0] byte_role
  output logic             out_tlast   // chunk_end_echo
);

  localparam logic [LenW-1:0]  LenMax = {LenW{1'b1}};
  localparam int               MulW   = LenW + 4;

  // Input register.
  logic            s1_valid_r;
  logic [7:0]      s1_data_r;
  logic            s1_last_r;

  // Result register.
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  role_t           out_role_r;
  logic            out_used_r;
  logic [CodeW-1:0] out_code_r;
  logic            out_sl_done_r;
  logic            out_hdr_done_r;
  logic [LenW-1:0] out_len_r;
  logic            out_msg_done_r;
  logic            out_last_r;

  // Parse state.
  phase_t              phase_r, phase_nxt;
  logic                cr_pend_r, cr_pend_nxt;
  logic                skip_r, skip_nxt;
  logic [CodeW-1:0]    code_acc_r, code_acc_nxt;
  logic                code_stop_r, code_stop_nxt;
  logic [KeyIdxW-1:0]  key_idx_r, key_idx_nxt;
  logic                key_miss_r, key_miss_nxt;
  logic [LenW-1:0]     val_acc_r, val_acc_nxt;
  logic                val_stop_r, val_stop_nxt;
  logic [LenW-1:0]     len_r, len_nxt;
  logic                len_found_r, len_found_nxt;
  logic [LenW-1:0]     body_rem_r, body_rem_nxt;
  role_t               role;
  logic                used;

  logic                advance;
  logic                step;
  logic                is_digit;
  logic [3:0]          digit_val;
  logic [CodeW+3:0]    code_mul;
  logic [MulW-1:0]     val_mul;
  logic                commit;

  // Advance the pipe when the result register is empty or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  assign is_digit  = (s1_data_r >= ChZero) && (s1_data_r <= ChNine);
  assign digit_val = 4'(s1_data_r - ChZero);
  assign code_mul  = ({4'b0, code_acc_r} << 3) + ({4'b0, code_acc_r} << 1)
                   + (CodeW+4)'(digit_val);
  assign val_mul   = ({4'b0, val_acc_r} << 3) + ({4'b0, val_acc_r} << 1)
                   + MulW'(digit_val);
  assign commit    = !key_miss_r && (key_idx_r == KeyIdxW'(KeyLen));

  // One parse step for the byte in the input register.
  always_comb begin
    phase_nxt     = phase_r;
    cr_pend_nxt   = cr_pend_r;
    skip_nxt      = skip_r;
    code_acc_nxt  = code_acc_r;
    code_stop_nxt = code_stop_r;
    key_idx_nxt   = key_idx_r;
    key_miss_nxt  = key_miss_r;
    val_acc_nxt   = val_acc_r;
    val_stop_nxt  = val_stop_r;
    len_nxt       = len_r;
    len_found_nxt = len_found_r;
    body_rem_nxt  = body_rem_r;
    role          = ROLE_SEP;
    used          = 1'b1;

    priority if (phase_r == PH_DONE) begin
      role = ROLE_UNUSED;
      used = 1'b0;
    end else if (phase_r == PH_BODY) begin
      role = ROLE_BODY;
      if (body_rem_r != '0) begin
        body_rem_nxt = body_rem_r - LenW'(1);
      end
      if (body_rem_r <= LenW'(1)) begin
        phase_nxt = PH_DONE;
      end
    end else if (cr_pend_r && s1_data_r == ChLf) begin
      // CR LF: end the line.
      cr_pend_nxt = 1'b0;
      role        = ROLE_SEP;
      if (phase_r == PH_NAME) begin
        // Line with no colon: headers end.
        if (len_found_r && len_r != '0) begin
          body_rem_nxt = len_r;
          phase_nxt    = PH_BODY;
        end else begin
          body_rem_nxt = '0;
          phase_nxt    = PH_DONE;
        end
      end else begin
        if (phase_r == PH_VALUE && commit) begin
          len_nxt       = val_acc_r;
          len_found_nxt = 1'b1;
        end
        phase_nxt    = PH_NAME;
        key_idx_nxt  = '0;
        key_miss_nxt = 1'b0;
        skip_nxt     = 1'b0;
      end
    end else if (s1_data_r == ChCr) begin
      // Tag CR as a separator; it acts as content if no LF follows.
      cr_pend_nxt = 1'b1;
      role        = ROLE_SEP;
      unique case (phase_r)
        PH_CODE: begin
          skip_nxt      = 1'b0;
          code_stop_nxt = 1'b1;
        end
        PH_REASON: skip_nxt = 1'b0;
        PH_NAME:   key_miss_nxt = 1'b1;
        PH_VALUE: begin
          skip_nxt     = 1'b0;
          val_stop_nxt = 1'b1;
        end
        default: ;
      endcase
    end else begin
      cr_pend_nxt = 1'b0;
      unique case (phase_r)
        PH_VERSION: begin
          if (s1_data_r == ChSpace) begin
            phase_nxt = PH_CODE;
            skip_nxt  = 1'b1;
            role      = ROLE_SEP;
          end else begin
            role = ROLE_VERSION;
          end
        end
        PH_CODE: begin
          if (s1_data_r == ChSpace) begin
            if (!skip_r) begin
              phase_nxt = PH_REASON;
            end
            skip_nxt = 1'b1;
            role     = ROLE_SEP;
          end else begin
            skip_nxt = 1'b0;
            role     = ROLE_CODE;
            if (is_digit && !code_stop_r) begin
              code_acc_nxt = (code_mul > (CodeW+4)'(CodeMax)) ? CodeMax
                                                              : CodeW'(code_mul);
            end else begin
              code_stop_nxt = 1'b1;
            end
          end
        end
        PH_REASON: begin
          if (skip_r && s1_data_r == ChSpace) begin
            role = ROLE_SEP;
          end else begin
            skip_nxt = 1'b0;
            role     = ROLE_REASON;
          end
        end
        PH_NAME: begin
          if (s1_data_r == ChColon) begin
            phase_nxt    = PH_VALUE;
            skip_nxt     = 1'b1;
            val_acc_nxt  = '0;
            val_stop_nxt = 1'b0;
            role         = ROLE_SEP;
          end else begin
            role = ROLE_NAME;
            if (!key_miss_r && key_idx_r < KeyIdxW'(KeyLen)
                && s1_data_r == key_char(key_idx_r)) begin
              key_idx_nxt = key_idx_r + KeyIdxW'(1);
            end else begin
              key_miss_nxt = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (skip_r && s1_data_r == ChSpace) begin
            role = ROLE_SEP;
          end else begin
            skip_nxt = 1'b0;
            role     = ROLE_VALUE;
            if (is_digit && !val_stop_r) begin
              val_acc_nxt = (val_mul > MulW'(LenMax)) ? LenMax : LenW'(val_mul);
            end else begin
              val_stop_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control and parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_VERSION;
      cr_pend_r   <= 1'b0;
      skip_r      <= 1'b0;
      code_acc_r  <= '0;
      code_stop_r <= 1'b0;
      key_idx_r   <= '0;
      key_miss_r  <= 1'b0;
      val_acc_r   <= '0;
      val_stop_r  <= 1'b0;
      len_r       <= '0;
      len_found_r <= 1'b0;
      body_rem_r  <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        phase_r     <= phase_nxt;
        cr_pend_r   <= cr_pend_nxt;
        skip_r      <= skip_nxt;
        code_acc_r  <= code_acc_nxt;
        code_stop_r <= code_stop_nxt;
        key_idx_r   <= key_idx_nxt;
        key_miss_r  <= key_miss_nxt;
        val_acc_r   <= val_acc_nxt;
        val_stop_r  <= val_stop_nxt;
        len_r       <= len_nxt;
        len_found_r <= len_found_nxt;
        body_rem_r  <= body_rem_nxt;
      end
    end
  end

  // Payload registers: load the input beat, then the result beat.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (step) begin
      out_byte_r     <= s1_data_r;
      out_role_r     <= role;
      out_used_r     <= used;
      out_code_r     <= code_acc_nxt;
      out_sl_done_r  <= phase_nxt == PH_NAME || phase_nxt == PH_VALUE
                     || phase_nxt == PH_BODY || phase_nxt == PH_DONE;
      out_hdr_done_r <= phase_nxt == PH_BODY || phase_nxt == PH_DONE;
      out_len_r      <= len_nxt;
      out_msg_done_r <= phase_nxt == PH_DONE;
      out_last_r     <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_msg_done_r, out_len_r, out_hdr_done_r,
                       out_sl_done_r, out_code_r, out_used_r, out_byte_r};
  assign out_tuser  = out_role_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A completed message implies both the status line and headers are done.
  a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_msg_done_r |-> out_hdr_done_r && out_sl_done_r)
    else $error("message done without headers done");

  // Not-consumed role and the consumed flag agree.
  a_used_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_used_r == (out_role_r != ROLE_UNUSED)))
    else $error("consumed flag disagrees with role");

  // The body phase always has bytes left to count.
  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> body_rem_r != '0)
    else $error("body phase with zero remaining");
`endif

endmodule
`default_nettype wire
